// ===== src/socks5hs_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the SOCKS5 client handshake unit.
// No dependencies; used by the handshake unit and the checker under src.
package socks5hs_pkg;

   localparam int NameStoreDepth = 256;

   localparam logic [2:0] CMD_LOAD_DEST = 3'd0;
   localparam logic [2:0] CMD_LOAD_USER = 3'd1;
   localparam logic [2:0] CMD_LOAD_PASS = 3'd2;
   localparam logic [2:0] CMD_START     = 3'd3;
   localparam logic [2:0] CMD_RX        = 3'd4;
   localparam logic [2:0] CMD_PULL      = 3'd5;
   localparam logic [2:0] CMD_EVENT     = 3'd6;
   localparam logic [2:0] CMD_NONE      = 3'd7;

   localparam logic [2:0] EVT_TIMEOUT    = 3'd0;
   localparam logic [2:0] EVT_DISCONNECT = 3'd1;

   localparam logic [2:0] REG_USE_AUTH  = 3'd0;
   localparam logic [2:0] REG_DEST_PORT = 3'd1;
   localparam logic [2:0] REG_DEST_LEN  = 3'd2;
   localparam logic [2:0] REG_USER_LEN  = 3'd3;
   localparam logic [2:0] REG_PASS_LEN  = 3'd4;

   localparam logic [3:0] ST_IDLE       = 4'd0;
   localparam logic [3:0] ST_BUSY       = 4'd1;
   localparam logic [3:0] ST_OK         = 4'd2;
   localparam logic [3:0] ST_TIMEOUT    = 4'd3;
   localparam logic [3:0] ST_LINK       = 4'd4;
   localparam logic [3:0] ST_BAD_GREET  = 4'd5;
   localparam logic [3:0] ST_BAD_METHOD = 4'd6;
   localparam logic [3:0] ST_AUTH_REJ   = 4'd7;
   localparam logic [3:0] ST_BAD_REPLY  = 4'd8;
   localparam logic [3:0] ST_REPLY_FAIL = 4'd9;
   localparam logic [3:0] ST_MALFORMED  = 4'd10;

   localparam logic [7:0] SOCKS_VER   = 8'h05;
   localparam logic [7:0] AUTH_VER    = 8'h01;
   localparam logic [7:0] METH_NONE   = 8'h00;
   localparam logic [7:0] METH_USER   = 8'h02;
   localparam logic [7:0] CMD_CONNECT = 8'h01;
   localparam logic [7:0] ATYP_IPV4   = 8'h01;
   localparam logic [7:0] ATYP_DOMAIN = 8'h03;
   localparam logic [7:0] ATYP_IPV6   = 8'h04;

   typedef enum logic [8:0] {
      PH_IDLE     = 9'b000000001,
      PH_GREET_TX = 9'b000000010,
      PH_GREET_RX = 9'b000000100,
      PH_AUTH_TX  = 9'b000001000,
      PH_AUTH_RX  = 9'b000010000,
      PH_CONN_TX  = 9'b000100000,
      PH_REPLY_RX = 9'b001000000,
      PH_SKIP_LEN = 9'b010000000,
      PH_SKIP     = 9'b100000000
   } phase_type;

endpackage

// ===== src/socks5hs_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read (old data on collision).
// No dependencies.
module socks5hs_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/socks5_client_handshake_unit.sv =====
`timescale 1ns / 1ps
// SOCKS5 client handshake engine: stores, phase control, tx byte and rx checks.
// Depends on socks5hs_pkg and socks5hs_ram.
//
//  channel | dir | handshake          | payload
//  req     | in  | req_tvalid/tready  | tdata: data_byte, load_index; tuser: command, event_kind
//  rsp     | out | rsp_tvalid/tready  | tdata: tx_byte, status, reply_code; tuser: tx_valid;
//          |     |                    | tlast: tx_last
//  csr     | in  | csr_we             | csr_addr, csr_wdata
//
// One beat per cycle while rsp is not stalled: a beat is held in the input register and its result
// is registered into the output register as it advances (rsp_tvalid follows both registers).
// Store bytes are prefetched from each RAM at the address the next position needs.
// Synchronous reset clears phase, counters, status and both valid flags.
// A stalled rsp holds the result; req is taken whenever the input register is empty or moves on.
module socks5_client_handshake_unit #(
   parameter int NAME_STORE_DEPTH = socks5hs_pkg::NameStoreDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] data_byte, [15:8] load_index
   input  logic [5:0]  req_tuser,   // [2:0] command, [5:3] event_kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] tx_byte, [11:8] status, [19:12] reply_code, pad
   output logic        rsp_tuser,   // [0] tx_valid
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   localparam int AW = $clog2(NAME_STORE_DEPTH);

   // configuration
   logic        use_auth_ff, use_auth_in;
   logic [15:0] dest_port_ff, dest_port_in;
   logic [7:0]  dl_ff, dl_in, ul_ff, ul_in, pl_ff, pl_in;

   always_comb begin
      use_auth_in  = use_auth_ff;
      dest_port_in = dest_port_ff;
      dl_in        = dl_ff;
      ul_in        = ul_ff;
      pl_in        = pl_ff;
      if (csr_we) begin
         case (csr_addr)
            socks5hs_pkg::REG_USE_AUTH:  use_auth_in  = csr_wdata[0];
            socks5hs_pkg::REG_DEST_PORT: dest_port_in = csr_wdata;
            socks5hs_pkg::REG_DEST_LEN:  dl_in        = csr_wdata[7:0];
            socks5hs_pkg::REG_USER_LEN:  ul_in        = csr_wdata[7:0];
            socks5hs_pkg::REG_PASS_LEN:  pl_in        = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_auth_ff  <= 1'b0;
         dest_port_ff <= '0;
         dl_ff        <= '0;
         ul_ff        <= '0;
         pl_ff        <= '0;
      end else begin
         use_auth_ff  <= use_auth_in;
         dest_port_ff <= dest_port_in;
         dl_ff        <= dl_in;
         ul_ff        <= ul_in;
         pl_ff        <= pl_in;
      end
   end

   // input register and output register
   logic        s1_valid_ff;
   logic [2:0]  s1_cmd_ff, s1_kind_ff;
   logic [7:0]  s1_data_ff, s1_idx_ff;
   logic        out_valid_ff;
   logic        out_tv_ff, out_tl_ff;
   logic [7:0]  out_tb_ff, out_rc_ff;
   logic [3:0]  out_st_ff;
   logic        adv;

   assign adv        = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         s1_cmd_ff  <= req_tuser[2:0];
         s1_kind_ff <= req_tuser[5:3];
         s1_data_ff <= req_tdata[7:0];
         s1_idx_ff  <= req_tdata[15:8];
      end
   end

   // handshake state
   socks5hs_pkg::phase_type phase_ff, phase_in;
   logic [9:0] pos_ff, pos_in;
   logic [7:0] hdr_ff [4];
   logic [7:0] hdr_in [4];
   logic [8:0] skip_ff, skip_in;
   logic [3:0] status_ff, status_in;
   logic [7:0] rc_ff, rc_in;

   // stores
   logic          ld_ok;
   logic [AW-1:0] wr_addr;
   logic          we_dest, we_user, we_pass;
   logic [9:0]    ra_dest, ra_user, ra_pass;
   logic [7:0]    rd_dest, rd_user, rd_pass;
   logic          hit_dest_ff, hit_user_ff, hit_pass_ff;
   logic [7:0]    byp_ff;
   logic [7:0]    dest_q, user_q, pass_q;

   assign ld_ok   = {1'b0, s1_idx_ff} < 9'(NAME_STORE_DEPTH);
   assign wr_addr = s1_idx_ff[AW-1:0];
   assign we_dest = adv && ld_ok && s1_cmd_ff == socks5hs_pkg::CMD_LOAD_DEST;
   assign we_user = adv && ld_ok && s1_cmd_ff == socks5hs_pkg::CMD_LOAD_USER;
   assign we_pass = adv && ld_ok && s1_cmd_ff == socks5hs_pkg::CMD_LOAD_PASS;

   // prefetch at the next position
   assign ra_dest = pos_in - 10'd5;
   assign ra_user = pos_in - 10'd2;
   assign ra_pass = pos_in - 10'd3 - {2'b00, ul_in};

   socks5hs_ram #(.Width(8), .Depth(NAME_STORE_DEPTH)) u_dest_ram (
      .clock(clock), .wr_en(we_dest), .wr_addr(wr_addr), .wr_data(s1_data_ff),
      .rd_addr(ra_dest[AW-1:0]), .rd_data(rd_dest));
   socks5hs_ram #(.Width(8), .Depth(NAME_STORE_DEPTH)) u_user_ram (
      .clock(clock), .wr_en(we_user), .wr_addr(wr_addr), .wr_data(s1_data_ff),
      .rd_addr(ra_user[AW-1:0]), .rd_data(rd_user));
   socks5hs_ram #(.Width(8), .Depth(NAME_STORE_DEPTH)) u_pass_ram (
      .clock(clock), .wr_en(we_pass), .wr_addr(wr_addr), .wr_data(s1_data_ff),
      .rd_addr(ra_pass[AW-1:0]), .rd_data(rd_pass));

   // forward a load that hits the address being prefetched in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_dest_ff <= 1'b0;
         hit_user_ff <= 1'b0;
         hit_pass_ff <= 1'b0;
      end else begin
         hit_dest_ff <= we_dest && wr_addr == ra_dest[AW-1:0];
         hit_user_ff <= we_user && wr_addr == ra_user[AW-1:0];
         hit_pass_ff <= we_pass && wr_addr == ra_pass[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      byp_ff <= s1_data_ff;
   end

   assign dest_q = hit_dest_ff ? byp_ff : rd_dest;
   assign user_q = hit_user_ff ? byp_ff : rd_user;
   assign pass_q = hit_pass_ff ? byp_ff : rd_pass;

   // one beat of work
   logic       tv, tl;
   logic [7:0] tb;
   logic [9:0] len, p1, sidx;
   logic       in_rng;
   logic [9:0] ul10, pl10, dl10;
   logic       need_done;

   assign ul10 = {2'b00, ul_ff};
   assign pl10 = {2'b00, pl_ff};
   assign dl10 = {2'b00, dl_ff};
   assign p1   = pos_ff + 10'd1;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      hdr_in    = hdr_ff;
      skip_in   = skip_ff;
      status_in = status_ff;
      rc_in     = rc_ff;
      tv        = 1'b0;
      tb        = '0;
      tl        = 1'b0;
      len       = '0;
      sidx      = '0;
      in_rng    = 1'b0;
      need_done = 1'b0;

      if (adv) begin
         case (s1_cmd_ff)
            socks5hs_pkg::CMD_START: begin
               phase_in  = socks5hs_pkg::PH_GREET_TX;
               pos_in    = '0;
               skip_in   = '0;
               status_in = socks5hs_pkg::ST_BUSY;
               rc_in     = '0;
            end
            socks5hs_pkg::CMD_PULL: begin
               if (phase_ff == socks5hs_pkg::PH_GREET_TX) begin
                  tv  = 1'b1;
                  len = use_auth_ff ? 10'd4 : 10'd3;
                  if (pos_ff == 10'd0)      tb = socks5hs_pkg::SOCKS_VER;
                  else if (pos_ff == 10'd1) tb = use_auth_ff ? 8'h02 : 8'h01;
                  else if (pos_ff == 10'd2) tb = socks5hs_pkg::METH_NONE;
                  else                      tb = socks5hs_pkg::METH_USER;
               end else if (phase_ff == socks5hs_pkg::PH_AUTH_TX) begin
                  tv  = 1'b1;
                  len = 10'd3 + ul10 + pl10;
                  if (pos_ff == 10'd0)      tb = socks5hs_pkg::AUTH_VER;
                  else if (pos_ff == 10'd1) tb = ul_ff;
                  else if (pos_ff < 10'd2 + ul10) begin
                     sidx = pos_ff - 10'd2;
                     in_rng = sidx < 10'(NAME_STORE_DEPTH);
                     tb = in_rng ? user_q : 8'h00;
                  end else if (pos_ff == 10'd2 + ul10) tb = pl_ff;
                  else begin
                     sidx = pos_ff - 10'd3 - ul10;
                     in_rng = sidx < 10'(NAME_STORE_DEPTH);
                     tb = in_rng ? pass_q : 8'h00;
                  end
               end else if (phase_ff == socks5hs_pkg::PH_CONN_TX) begin
                  tv  = 1'b1;
                  len = 10'd7 + dl10;
                  if (pos_ff == 10'd0)      tb = socks5hs_pkg::SOCKS_VER;
                  else if (pos_ff == 10'd1) tb = socks5hs_pkg::CMD_CONNECT;
                  else if (pos_ff == 10'd2) tb = 8'h00;
                  else if (pos_ff == 10'd3) tb = socks5hs_pkg::ATYP_DOMAIN;
                  else if (pos_ff == 10'd4) tb = dl_ff;
                  else if (pos_ff < 10'd5 + dl10) begin
                     sidx = pos_ff - 10'd5;
                     in_rng = sidx < 10'(NAME_STORE_DEPTH);
                     tb = in_rng ? dest_q : 8'h00;
                  end else if (pos_ff == 10'd5 + dl10) tb = dest_port_ff[15:8];
                  else tb = dest_port_ff[7:0];
               end
               if (tv) begin
                  if ({1'b0, pos_ff} + 11'd1 >= {1'b0, len}) begin
                     tl     = 1'b1;
                     pos_in = '0;
                     if (phase_ff == socks5hs_pkg::PH_GREET_TX)
                        phase_in = socks5hs_pkg::PH_GREET_RX;
                     else if (phase_ff == socks5hs_pkg::PH_AUTH_TX)
                        phase_in = socks5hs_pkg::PH_AUTH_RX;
                     else
                        phase_in = socks5hs_pkg::PH_REPLY_RX;
                  end else begin
                     pos_in = p1;
                  end
               end
            end
            socks5hs_pkg::CMD_RX: begin
               if (phase_ff == socks5hs_pkg::PH_GREET_RX ||
                   phase_ff == socks5hs_pkg::PH_AUTH_RX ||
                   phase_ff == socks5hs_pkg::PH_REPLY_RX) begin
                  hdr_in[pos_ff[1:0]] = s1_data_ff;
                  need_done = (phase_ff == socks5hs_pkg::PH_REPLY_RX) ?
                              (p1 >= 10'd4) : (p1 >= 10'd2);
                  if (!need_done) begin
                     pos_in = p1;
                  end else begin
                     pos_in = '0;
                     if (phase_ff == socks5hs_pkg::PH_GREET_RX) begin
                        if (hdr_in[0] != socks5hs_pkg::SOCKS_VER) begin
                           phase_in = socks5hs_pkg::PH_IDLE;
                           status_in = socks5hs_pkg::ST_BAD_GREET;
                        end else if (hdr_in[1] == socks5hs_pkg::METH_USER && use_auth_ff)
                           phase_in = socks5hs_pkg::PH_AUTH_TX;
                        else if (hdr_in[1] == socks5hs_pkg::METH_NONE)
                           phase_in = socks5hs_pkg::PH_CONN_TX;
                        else begin
                           phase_in = socks5hs_pkg::PH_IDLE;
                           status_in = socks5hs_pkg::ST_BAD_METHOD;
                        end
                     end else if (phase_ff == socks5hs_pkg::PH_AUTH_RX) begin
                        if (hdr_in[0] != socks5hs_pkg::AUTH_VER || hdr_in[1] != 8'h00) begin
                           phase_in = socks5hs_pkg::PH_IDLE;
                           status_in = socks5hs_pkg::ST_AUTH_REJ;
                        end else phase_in = socks5hs_pkg::PH_CONN_TX;
                     end else begin
                        if (hdr_in[0] != socks5hs_pkg::SOCKS_VER) begin
                           phase_in = socks5hs_pkg::PH_IDLE;
                           status_in = socks5hs_pkg::ST_BAD_REPLY;
                        end else if (hdr_in[1] != 8'h00) begin
                           rc_in = hdr_in[1];
                           phase_in = socks5hs_pkg::PH_IDLE;
                           status_in = socks5hs_pkg::ST_REPLY_FAIL;
                        end else if (hdr_in[2] != 8'h00) begin
                           phase_in = socks5hs_pkg::PH_IDLE;
                           status_in = socks5hs_pkg::ST_MALFORMED;
                        end else if (hdr_in[3] == socks5hs_pkg::ATYP_IPV4) begin
                           skip_in = 9'd6;
                           phase_in = socks5hs_pkg::PH_SKIP;
                        end else if (hdr_in[3] == socks5hs_pkg::ATYP_IPV6) begin
                           skip_in = 9'd18;
                           phase_in = socks5hs_pkg::PH_SKIP;
                        end else if (hdr_in[3] == socks5hs_pkg::ATYP_DOMAIN)
                           phase_in = socks5hs_pkg::PH_SKIP_LEN;
                        else begin
                           phase_in = socks5hs_pkg::PH_IDLE;
                           status_in = socks5hs_pkg::ST_MALFORMED;
                        end
                     end
                  end
               end else if (phase_ff == socks5hs_pkg::PH_SKIP_LEN) begin
                  skip_in  = {1'b0, s1_data_ff} + 9'd2;
                  phase_in = socks5hs_pkg::PH_SKIP;
               end else if (phase_ff == socks5hs_pkg::PH_SKIP) begin
                  if (skip_ff != 9'd0) skip_in = skip_ff - 9'd1;
                  if (skip_in == 9'd0) begin
                     phase_in = socks5hs_pkg::PH_IDLE;
                     pos_in = '0;
                     status_in = socks5hs_pkg::ST_OK;
                  end
               end
            end
            socks5hs_pkg::CMD_EVENT: begin
               if (status_ff == socks5hs_pkg::ST_BUSY) begin
                  phase_in = socks5hs_pkg::PH_IDLE;
                  pos_in = '0;
                  status_in = (s1_kind_ff == socks5hs_pkg::EVT_TIMEOUT) ?
                              socks5hs_pkg::ST_TIMEOUT : socks5hs_pkg::ST_LINK;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= socks5hs_pkg::PH_IDLE;
         pos_ff    <= '0;
         skip_ff   <= '0;
         status_ff <= socks5hs_pkg::ST_IDLE;
         rc_ff     <= '0;
         for (int i = 0; i < 4; i++) hdr_ff[i] <= '0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         skip_ff   <= skip_in;
         status_ff <= status_in;
         rc_ff     <= rc_in;
         hdr_ff    <= hdr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_tv_ff <= tv;
         out_tb_ff <= tb;
         out_tl_ff <= tl;
         out_st_ff <= status_in;
         out_rc_ff <= rc_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_rc_ff, out_st_ff, out_tb_ff};
   assign rsp_tuser  = out_tv_ff;
   assign rsp_tlast  = out_tl_ff;

endmodule

// ===== src/socks5hs_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the handshake unit's result channel, bound to the top level.
// Depends on socks5hs_pkg and socks5_client_handshake_unit.
module socks5hs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("tx_last without tx_valid");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[7:0] == 8'h00)
      else $error("tx_byte set without tx_valid");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[19:12] != 8'h00 |->
         rsp_tdata[11:8] == socks5hs_pkg::ST_REPLY_FAIL)
      else $error("reply_code set outside reply failure");

endmodule

bind socks5_client_handshake_unit socks5hs_checker u_socks5hs_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast));

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for socks5_client_handshake_unit: random and directed beats,
// a cycle-free predictor of the handshake engine, and a response scoreboard.
// Depends on socks5hs_pkg and the unit under src.
module tb_top;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] data;
      logic [7:0] idx;
      logic [2:0] kind;
   } req_beat_type;

   typedef struct packed {
      logic       tv;
      logic [7:0] tb;
      logic       tl;
      logic [3:0] st;
      logic [7:0] rc;
   } rsp_beat_type;

   // an event kind outside the named ones still ends the exchange as a link error
   localparam logic [2:0] EVT_OUT_OF_RANGE = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [15:0] req_tdata = '0;
   logic [5:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;
   logic csr_we = 1'b0;
   logic [2:0] csr_addr = '0;
   logic [15:0] csr_wdata = '0;

   socks5_client_handshake_unit dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic use_auth;
   logic [15:0] dport;
   logic [7:0] dlen, ulen, plen;
   socks5hs_pkg::phase_type ph;
   int unsigned pos, skip_left;
   logic [7:0] hdr [4];
   logic [7:0] dest_mem [256], user_mem [256], pass_mem [256];
   logic [3:0] status_q;
   logic [7:0] code_q;

   req_beat_type pending_reqs [$];
   rsp_beat_type expected_rsps [$];
   int errors = 0;
   int sent = 0;
   bit stim_done = 0;
   int gap_in = 0, gap_out = 0;

   task automatic report(input string what, input rsp_beat_type got, input rsp_beat_type exp);
      $display("error %0d at %0t: %s got %p exp %p", errors, $time, what, got, exp);
      errors++;
   endtask

   function automatic int rnd_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void end_hs(input logic [3:0] st);
      ph = socks5hs_pkg::PH_IDLE;
      pos = 0;
      status_q = st;
   endfunction

   function automatic logic [7:0] tx_at(input int unsigned p, output int unsigned len);
      if (ph == socks5hs_pkg::PH_GREET_TX) begin
         len = use_auth ? 4 : 3;
         if (p == 0) return socks5hs_pkg::SOCKS_VER;
         if (p == 1) return use_auth ? 8'h02 : 8'h01;
         if (p == 2) return socks5hs_pkg::METH_NONE;
         return socks5hs_pkg::METH_USER;
      end
      if (ph == socks5hs_pkg::PH_AUTH_TX) begin
         len = 3 + ulen + plen;
         if (p == 0) return socks5hs_pkg::AUTH_VER;
         if (p == 1) return ulen;
         if (p < 2 + ulen) return user_mem[p - 2];
         if (p == 2 + ulen) return plen;
         return pass_mem[p - 3 - ulen];
      end
      len = 7 + dlen;
      if (p == 0) return socks5hs_pkg::SOCKS_VER;
      if (p == 1) return socks5hs_pkg::CMD_CONNECT;
      if (p == 2) return 8'h00;
      if (p == 3) return socks5hs_pkg::ATYP_DOMAIN;
      if (p == 4) return dlen;
      if (p < 5 + dlen) return dest_mem[p - 5];
      if (p == 5 + dlen) return dport[15:8];
      return dport[7:0];
   endfunction

   function automatic void take_rx(input logic [7:0] b);
      int unsigned need;
      if (ph inside {socks5hs_pkg::PH_GREET_RX, socks5hs_pkg::PH_AUTH_RX,
                     socks5hs_pkg::PH_REPLY_RX}) begin
         need = (ph == socks5hs_pkg::PH_REPLY_RX) ? 4 : 2;
         hdr[pos & 3] = b;
         pos++;
         if (pos < need) return;
         pos = 0;
         if (ph == socks5hs_pkg::PH_GREET_RX) begin
            if (hdr[0] != socks5hs_pkg::SOCKS_VER) end_hs(socks5hs_pkg::ST_BAD_GREET);
            else if (hdr[1] == socks5hs_pkg::METH_USER && use_auth)
               ph = socks5hs_pkg::PH_AUTH_TX;
            else if (hdr[1] == socks5hs_pkg::METH_NONE) ph = socks5hs_pkg::PH_CONN_TX;
            else end_hs(socks5hs_pkg::ST_BAD_METHOD);
         end else if (ph == socks5hs_pkg::PH_AUTH_RX) begin
            if (hdr[0] != socks5hs_pkg::AUTH_VER || hdr[1] != 8'h00)
               end_hs(socks5hs_pkg::ST_AUTH_REJ);
            else ph = socks5hs_pkg::PH_CONN_TX;
         end else begin
            if (hdr[0] != socks5hs_pkg::SOCKS_VER) end_hs(socks5hs_pkg::ST_BAD_REPLY);
            else if (hdr[1] != 8'h00) begin
               code_q = hdr[1];
               end_hs(socks5hs_pkg::ST_REPLY_FAIL);
            end else if (hdr[2] != 8'h00) end_hs(socks5hs_pkg::ST_MALFORMED);
            else if (hdr[3] == socks5hs_pkg::ATYP_IPV4) begin
               skip_left = 6;
               ph = socks5hs_pkg::PH_SKIP;
            end else if (hdr[3] == socks5hs_pkg::ATYP_IPV6) begin
               skip_left = 18;
               ph = socks5hs_pkg::PH_SKIP;
            end else if (hdr[3] == socks5hs_pkg::ATYP_DOMAIN) ph = socks5hs_pkg::PH_SKIP_LEN;
            else end_hs(socks5hs_pkg::ST_MALFORMED);
         end
      end else if (ph == socks5hs_pkg::PH_SKIP_LEN) begin
         skip_left = b + 2;
         ph = socks5hs_pkg::PH_SKIP;
      end else if (ph == socks5hs_pkg::PH_SKIP) begin
         if (skip_left > 0) skip_left--;
         if (skip_left == 0) end_hs(socks5hs_pkg::ST_OK);
      end
   endfunction

   function automatic rsp_beat_type predict_handshake(input req_beat_type r);
      rsp_beat_type o;
      int unsigned len;
      o = '0;
      case (r.cmd)
         socks5hs_pkg::CMD_LOAD_DEST: dest_mem[r.idx] = r.data;
         socks5hs_pkg::CMD_LOAD_USER: user_mem[r.idx] = r.data;
         socks5hs_pkg::CMD_LOAD_PASS: pass_mem[r.idx] = r.data;
         socks5hs_pkg::CMD_START: begin
            ph = socks5hs_pkg::PH_GREET_TX;
            pos = 0;
            skip_left = 0;
            status_q = socks5hs_pkg::ST_BUSY;
            code_q = 0;
         end
         socks5hs_pkg::CMD_RX: take_rx(r.data);
         socks5hs_pkg::CMD_PULL:
            if (ph inside {socks5hs_pkg::PH_GREET_TX, socks5hs_pkg::PH_AUTH_TX,
                           socks5hs_pkg::PH_CONN_TX}) begin
               o.tb = tx_at(pos, len);
               o.tv = 1'b1;
               if (pos + 1 >= len) begin
                  o.tl = 1'b1;
                  pos = 0;
                  ph = (ph == socks5hs_pkg::PH_GREET_TX) ? socks5hs_pkg::PH_GREET_RX :
                       (ph == socks5hs_pkg::PH_AUTH_TX) ? socks5hs_pkg::PH_AUTH_RX :
                       socks5hs_pkg::PH_REPLY_RX;
               end else pos = (pos + 1) & 10'h3ff;
            end
         socks5hs_pkg::CMD_EVENT:
            if (status_q == socks5hs_pkg::ST_BUSY)
               end_hs(r.kind == socks5hs_pkg::EVT_TIMEOUT ? socks5hs_pkg::ST_TIMEOUT :
                      socks5hs_pkg::ST_LINK);
         default: ;
      endcase
      o.st = status_q;
      o.rc = code_q;
      return o;
   endfunction

   // driver: pop a beat when the previous one was taken, with random gaps
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_rsps = {expected_rsps,
                             predict_handshake({req_tuser[2:0], req_tdata[7:0],
                                                req_tdata[15:8], req_tuser[5:3]})};
         end
         if (!req_tvalid || req_tready) begin
            if (gap_in > 0) begin
               gap_in <= gap_in - 1;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_beat_type b;
               b = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {b.idx, b.data};
               req_tuser <= {b.kind, b.cmd};
               gap_in <= rnd_gap();
            end else req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: compare each taken result with the oldest expectation
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_beat_type got, exp;
            got = {rsp_tuser, rsp_tdata[7:0], rsp_tlast, rsp_tdata[11:8], rsp_tdata[19:12]};
            if (expected_rsps.size() == 0) report("unexpected beat", got, got);
            else begin
               exp = expected_rsps.pop_front();
               if (got.tv != exp.tv) report("tx_valid", got, exp);
               if (got.tb != exp.tb) report("tx_byte", got, exp);
               if (got.tl != exp.tl) report("tx_last", got, exp);
               if (got.st != exp.st) report("status", got, exp);
               if (got.rc != exp.rc) report("reply_code", got, exp);
            end
         end
         if (gap_out > 0) begin
            gap_out <= gap_out - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) gap_out <= rnd_gap();
         end
      end
   end

   task automatic push(input logic [2:0] c, input logic [7:0] d = 0, input logic [7:0] i = 0,
                       input logic [2:0] k = 0);
      req_beat_type b;
      b.cmd = c; b.data = d; b.idx = i; b.kind = k;
      pending_reqs = {pending_reqs, b};
      sent++;
   endtask

   task automatic csr_write(input logic [2:0] a, input logic [15:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= a;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      case (a)
         socks5hs_pkg::REG_USE_AUTH: use_auth = v[0];
         socks5hs_pkg::REG_DEST_PORT: dport = v;
         socks5hs_pkg::REG_DEST_LEN: dlen = v[7:0];
         socks5hs_pkg::REG_USER_LEN: ulen = v[7:0];
         socks5hs_pkg::REG_PASS_LEN: plen = v[7:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      wait (pending_reqs.size() == 0 && !req_tvalid && expected_rsps.size() == 0);
      repeat (6) @(posedge clock);
   endtask

   // load every store entry that a message can reach, so no unwritten read occurs
   task automatic fill_stores();
      for (int i = 0; i < 256; i++) begin
         push(socks5hs_pkg::CMD_LOAD_DEST, 8'($urandom), 8'(i));
         push(socks5hs_pkg::CMD_LOAD_USER, 8'($urandom), 8'(i));
         push(socks5hs_pkg::CMD_LOAD_PASS, 8'($urandom), 8'(i));
      end
   endtask

   task automatic rx_bytes(input logic [7:0] a, input logic [7:0] b);
      push(socks5hs_pkg::CMD_RX, a);
      push(socks5hs_pkg::CMD_RX, b);
   endtask

   // one exchange: mostly well formed, sometimes broken replies or noise
   task automatic random_exchange();
      int n, bad;
      bad = $urandom_range(0, 9);
      push(socks5hs_pkg::CMD_START);
      repeat (use_auth ? 4 : 3) push(socks5hs_pkg::CMD_PULL);
      if (bad == 0) rx_bytes(8'($urandom), 8'($urandom));
      else rx_bytes(socks5hs_pkg::SOCKS_VER,
                    use_auth && $urandom_range(0, 1) ? socks5hs_pkg::METH_USER :
                    ($urandom_range(0, 9) == 0 ? 8'hff : socks5hs_pkg::METH_NONE));
      if (use_auth) begin
         repeat (3 + ulen + plen) push(socks5hs_pkg::CMD_PULL);
         rx_bytes(bad == 1 ? 8'h01 : socks5hs_pkg::AUTH_VER, bad == 2 ? 8'($urandom) : 8'h00);
      end
      repeat (7 + dlen) push(socks5hs_pkg::CMD_PULL);
      push(socks5hs_pkg::CMD_RX, bad == 3 ? 8'($urandom) : socks5hs_pkg::SOCKS_VER);
      push(socks5hs_pkg::CMD_RX, bad == 4 ? 8'($urandom) : 8'h00);
      push(socks5hs_pkg::CMD_RX, bad == 5 ? 8'($urandom) : 8'h00);
      n = $urandom_range(0, 3);
      push(socks5hs_pkg::CMD_RX, bad == 6 ? 8'($urandom) :
           (n == 0 ? socks5hs_pkg::ATYP_IPV4 :
            n == 1 ? socks5hs_pkg::ATYP_IPV6 : socks5hs_pkg::ATYP_DOMAIN));
      n = $urandom_range(0, 9) == 0 ? 255 : $urandom_range(0, 7);
      push(socks5hs_pkg::CMD_RX, 8'(n));
      repeat (20) push(socks5hs_pkg::CMD_RX, 8'($urandom));
      if ($urandom_range(0, 7) == 0)
         push(socks5hs_pkg::CMD_EVENT, 8'h00, 8'h00, 3'($urandom));
      if ($urandom_range(0, 7) == 0)
         push(3'($urandom), 8'($urandom), 8'($urandom), 3'($urandom));
   endtask

   initial begin
      use_auth = 0; dport = 0; dlen = 0; ulen = 0; plen = 0;
      ph = socks5hs_pkg::PH_IDLE; pos = 0; skip_left = 0;
      status_q = socks5hs_pkg::ST_IDLE; code_q = 0;
      foreach (hdr[i]) hdr[i] = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      fill_stores();
      drain();
      // directed: plain greeting, no auth, failures and events
      push(socks5hs_pkg::CMD_PULL);
      push(socks5hs_pkg::CMD_RX, 8'hff);
      push(socks5hs_pkg::CMD_EVENT, 8'h00, 8'h00, socks5hs_pkg::EVT_DISCONNECT);
      push(socks5hs_pkg::CMD_START);
      repeat (3) push(socks5hs_pkg::CMD_PULL);
      push(socks5hs_pkg::CMD_PULL);
      rx_bytes(socks5hs_pkg::SOCKS_VER, socks5hs_pkg::METH_NONE);
      repeat (7) push(socks5hs_pkg::CMD_PULL);
      push(socks5hs_pkg::CMD_RX, socks5hs_pkg::SOCKS_VER);
      push(socks5hs_pkg::CMD_RX, 8'h00);
      push(socks5hs_pkg::CMD_RX, 8'h00);
      push(socks5hs_pkg::CMD_RX, socks5hs_pkg::ATYP_IPV4);
      repeat (6) push(socks5hs_pkg::CMD_RX, 8'hff);
      push(socks5hs_pkg::CMD_START);
      push(socks5hs_pkg::CMD_EVENT, 8'h00, 8'h00, socks5hs_pkg::EVT_TIMEOUT);
      push(socks5hs_pkg::CMD_START);
      push(socks5hs_pkg::CMD_EVENT, 8'h00, 8'h00, EVT_OUT_OF_RANGE);
      push(socks5hs_pkg::CMD_NONE, 8'hff, 8'hff, EVT_OUT_OF_RANGE);
      drain();
      csr_write(socks5hs_pkg::REG_USE_AUTH, 16'd1);
      csr_write(socks5hs_pkg::REG_DEST_PORT, 16'hffff);
      csr_write(socks5hs_pkg::REG_DEST_LEN, 16'd255);
      csr_write(socks5hs_pkg::REG_USER_LEN, 16'd255);
      csr_write(socks5hs_pkg::REG_PASS_LEN, 16'd255);
      random_exchange();
      drain();
      while (sent < 1950) begin
         csr_write(socks5hs_pkg::REG_USE_AUTH, 16'($urandom));
         csr_write(socks5hs_pkg::REG_DEST_PORT, 16'($urandom));
         csr_write(socks5hs_pkg::REG_DEST_LEN, 16'($urandom_range(0, 5) == 0 ?
                   $urandom_range(0, 40) : $urandom_range(0, 6)));
         csr_write(socks5hs_pkg::REG_USER_LEN, 16'($urandom_range(0, 5) == 0 ?
                   $urandom_range(0, 40) : $urandom_range(0, 4)));
         csr_write(socks5hs_pkg::REG_PASS_LEN, 16'($urandom_range(0, 5) == 0 ?
                   $urandom_range(0, 40) : $urandom_range(0, 4)));
         repeat ($urandom_range(1, 3)) random_exchange();
         drain();
      end
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      if (errors == 0) $display("socks5_client_handshake_unit: match");
      else $display("socks5_client_handshake_unit: mismatch");
      $finish;
   end

   initial begin
      #4000000;
      $display("socks5_client_handshake_unit: mismatch");
      $finish;
   end
endmodule
